[rtl/ps2_mouse_packet_decoder_assert.svh]
// Assertion macros for the PS/2 mouse packet decoder.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef PS2_MOUSE_PACKET_DECODER_ASSERT_SVH
`define PS2_MOUSE_PACKET_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PS2MD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2md assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PS2MD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2md assertion failed");

`endif

[rtl/ps2md_pkg.sv]
// Types, constants and helpers shared by the PS/2 mouse packet decoder.
// Used by ps2md_emit, ps2_mouse_packet_decoder and the testbench.
package ps2md_pkg;

    typedef enum logic [1:0] {
        EV_MOVE   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_WHEEL  = 2'd2
    } t_event_kind;

    localparam int SYNC_BIT  = 3;
    localparam int X_OVF_BIT = 6;
    localparam int Y_OVF_BIT = 7;
    localparam int NUM_BTN   = 3;
    // pending-event slots: move, three buttons, wheel
    localparam int NUM_SLOT  = 5;

    localparam logic signed [7:0] DELTA_MAX = 8'sd127;
    localparam logic signed [7:0] DELTA_MIN = -8'sd128;

    // One completed packet, ready to be broken into events.
    typedef struct packed {
        logic signed [7:0]         dx;
        logic signed [7:0]         dy;
        logic [NUM_BTN-1:0]        buttons;
        logic [NUM_BTN-1:0]        changed;
        logic                      wheel_en;
        logic signed [7:0]         wheel;
        logic signed [31:0]        pos_x;
        logic signed [31:0]        pos_y;
    } t_packet;

    typedef struct packed {
        t_event_kind               kind;
        logic signed [7:0]         dx;
        logic signed [7:0]         dy;
        logic [NUM_BTN-1:0]        buttons;
        logic [1:0]                index;
        logic                      pressed;
        logic signed [7:0]         wheel;
        logic signed [31:0]        pos_x;
        logic signed [31:0]        pos_y;
        logic                      last;
    } t_event;

    // Overflow forces the delta to full scale; a zero delta goes negative.
    function automatic logic signed [7:0] sat_delta(input logic [7:0] raw, input logic ovf);
        logic signed [7:0] d;
        d = signed'(raw);
        if (!ovf) begin
            return d;
        end
        return (d > 8'sd0) ? DELTA_MAX : DELTA_MIN;
    endfunction

endpackage

[rtl/ps2md_emit.sv]
// Event sequencer: holds one decoded packet; one event per cycle unless stalled.
// Depends on ps2md_pkg and ps2_mouse_packet_decoder_assert.svh.
module ps2md_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ps2md_pkg::t_packet i_pkt,
    input  logic              i_pkt_valid,
    output logic              o_pkt_ready,
    output ps2md_pkg::t_event o_evt,
    output logic              o_evt_valid,
    input  logic              i_evt_ready
);
    import ps2md_pkg::*;

    `include "ps2_mouse_packet_decoder_assert.svh"

    t_packet               r_pkt;
    logic [NUM_SLOT-1:0]   r_mask, n_mask;
    t_event                r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [NUM_SLOT-1:0]   w_pick;
    logic [NUM_SLOT-1:0]   w_rest;
    logic                  w_load;
    logic                  w_pkt_take;

    // lowest pending slot goes first: move, left, right, middle, wheel
    assign w_pick     = r_mask & (~r_mask + NUM_SLOT'(1));
    assign w_rest     = r_mask & ~w_pick;
    assign w_load     = (r_mask != '0) && (!r_out_valid || i_evt_ready);
    assign o_pkt_ready = (r_mask == '0) || (w_load && (w_rest == '0));
    assign w_pkt_take = i_pkt_valid && o_pkt_ready;

    always_comb begin
        n_out          = r_out;
        n_out_valid    = r_out_valid;
        if (r_out_valid && i_evt_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid    = 1'b1;
            n_out.kind     = EV_MOVE;
            n_out.dx       = '0;
            n_out.dy       = '0;
            n_out.buttons  = r_pkt.buttons;
            n_out.index    = '0;
            n_out.pressed  = 1'b0;
            n_out.wheel    = '0;
            n_out.pos_x    = r_pkt.pos_x;
            n_out.pos_y    = r_pkt.pos_y;
            n_out.last     = (w_rest == '0);
            priority if (w_pick[0]) begin
                n_out.dx = r_pkt.dx;
                n_out.dy = r_pkt.dy;
            end else if (w_pick[1]) begin
                n_out.kind    = EV_BUTTON;
                n_out.index   = 2'd0;
                n_out.pressed = r_pkt.buttons[0];
            end else if (w_pick[2]) begin
                n_out.kind    = EV_BUTTON;
                n_out.index   = 2'd1;
                n_out.pressed = r_pkt.buttons[1];
            end else if (w_pick[3]) begin
                n_out.kind    = EV_BUTTON;
                n_out.index   = 2'd2;
                n_out.pressed = r_pkt.buttons[2];
            end else begin
                n_out.kind  = EV_WHEEL;
                n_out.wheel = r_pkt.wheel;
            end
        end
    end

    always_comb begin
        n_mask = r_mask;
        if (w_pkt_take) begin
            n_mask = {i_pkt.wheel_en, i_pkt.changed, 1'b1};
        end else if (w_load) begin
            n_mask = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_pkt_take) begin
            r_pkt <= i_pkt;
        end
    end

    assign o_evt       = r_out;
    assign o_evt_valid = r_out_valid;

    `PS2MD_ASSERT_NEXT(a_take_queues_move, i_clk, i_rst_n, w_pkt_take, r_mask[0])
    `PS2MD_ASSERT_NOW(a_ready_one_left, i_clk, i_rst_n, o_pkt_ready && (r_mask != '0), $onehot(r_mask))
    `PS2MD_ASSERT_NOW(a_wheel_is_last, i_clk, i_rst_n, r_out_valid && (r_out.kind == EV_WHEEL), r_out.last)
    `PS2MD_ASSERT_NOW(a_move_heads_packet, i_clk, i_rst_n, w_load && w_pick[0], !(r_out_valid && !r_out.last))

endmodule

[rtl/ps2_mouse_packet_decoder.sv]
// PS/2 mouse packet decoder: byte assembly, delta saturation and position tracking.
// Depends on ps2md_pkg and ps2md_emit.
// A packet's first event is registered in the pending mask, then in the output register.
// Throughput: events leave one per cycle while the receiver is ready (1 to 5 per packet);
// any byte is held off while more than one event is left, or one is left and output stalls.
// Reset (synchronous, active low) clears bytes, positions, buttons, wheel mode and events.
module ps2_mouse_packet_decoder #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,    // wheel_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [7:0] delta_x, [15:8] delta_y, [18:16] button_state,
                                        // [20:19] button_index, [21] pressed,
                                        // [29:22] wheel_delta, [61:30] pos_x, [93:62] pos_y
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast    // last_of_packet
);
    import ps2md_pkg::*;

    logic                              r_wheel_mode;
    logic [7:0]                        r_hdr, r_x, r_y;
    logic [1:0]                        r_idx, n_idx;
    logic signed [POSITION_WIDTH-1:0]  r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [NUM_BTN-1:0]                r_prev_btn;

    logic       w_take, w_drop, w_done;
    logic [1:0] w_last_idx;
    logic [7:0] w_y;
    t_packet    w_pkt;
    t_event     w_evt;

    assign w_take     = s_axis_tvalid && s_axis_tready;
    assign w_drop     = (r_idx == 2'd0) && !s_axis_tdata[SYNC_BIT];
    assign w_last_idx = r_wheel_mode ? 2'd3 : 2'd2;
    assign w_done     = !w_drop && (r_idx >= w_last_idx);
    // at index two the y byte is the one arriving now
    assign w_y        = (r_idx == 2'd2) ? s_axis_tdata : r_y;

    always_comb begin
        w_pkt.dx       = sat_delta(r_x, r_hdr[X_OVF_BIT]);
        w_pkt.dy       = sat_delta(w_y, r_hdr[Y_OVF_BIT]);
        w_pkt.buttons  = r_hdr[NUM_BTN-1:0];
        w_pkt.changed  = r_hdr[NUM_BTN-1:0] ^ r_prev_btn;
        w_pkt.wheel_en = r_wheel_mode && (r_idx == 2'd3) && (s_axis_tdata != 8'd0);
        w_pkt.wheel    = signed'(s_axis_tdata);
        n_pos_x        = r_pos_x + POSITION_WIDTH'(w_pkt.dx);
        n_pos_y        = r_pos_y - POSITION_WIDTH'(w_pkt.dy);
        w_pkt.pos_x    = 32'(n_pos_x);
        w_pkt.pos_y    = 32'(n_pos_y);
    end

    always_comb begin
        n_idx = r_idx;
        if (!w_drop) begin
            n_idx = w_done ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
            r_idx        <= '0;
            r_hdr        <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_prev_btn   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wheel_mode <= i_cfg_wdata;
            end
            if (w_take) begin
                r_idx <= n_idx;
                if (!w_drop) begin
                    unique case (r_idx)
                        2'd0:    r_hdr <= s_axis_tdata;
                        2'd1:    r_x   <= s_axis_tdata;
                        2'd2:    r_y   <= s_axis_tdata;
                        default: ;
                    endcase
                end
                if (w_done) begin
                    r_pos_x    <= n_pos_x;
                    r_pos_y    <= n_pos_y;
                    r_prev_btn <= w_pkt.buttons;
                end
            end
        end
    end

    ps2md_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (w_pkt),
        .i_pkt_valid (s_axis_tvalid && w_done),
        .o_pkt_ready (s_axis_tready),
        .o_evt       (w_evt),
        .o_evt_valid (m_axis_tvalid),
        .i_evt_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, w_evt.pos_y, w_evt.pos_x, w_evt.wheel, w_evt.pressed,
                           w_evt.index, w_evt.buttons, w_evt.dy, w_evt.dx};
    assign m_axis_tuser = w_evt.kind;
    assign m_axis_tlast = w_evt.last;

endmodule

[tb/ps2_event_checker.sv]
// Event checker for the PS/2 mouse packet decoder testbench: watches the byte and event
// streams, predicts the events of each completed packet and compares them in order.
// Depends on ps2md_pkg for the event kinds, delta limits and the event record.
`timescale 1ns / 1ps

module ps2_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,   // [7:0] delta_x, [15:8] delta_y, [18:16] button_state,
                                        // [20:19] button_index, [21] pressed,
                                        // [29:22] wheel_delta, [61:30] pos_x, [93:62] pos_y
    input  logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    input  logic        m_axis_tlast,   // last_of_packet
    output int          o_pending,
    output int          o_fails
);
    import ps2md_pkg::*;

    logic        wheel_mode;
    logic [7:0]  hdr_byte;
    logic [7:0]  x_raw;
    logic [7:0]  y_raw;
    logic [1:0]  byte_pos;
    logic [31:0] cursor_x;
    logic [31:0] cursor_y;
    logic [2:0]  prev_btn;
    t_event      pending_events[$];
    int          mismatch_count;

    function automatic logic signed [7:0] clamp_delta(input logic [7:0] raw, input logic ovf);
        logic signed [7:0] d;
        d = signed'(raw);
        if (ovf) begin
            d = (d > 8'sd0) ? DELTA_MAX : DELTA_MIN;
        end
        return d;
    endfunction

    initial begin
        mismatch_count = 0;
    end

    always @(posedge i_clk) begin : watch
        t_event            evs[NUM_SLOT];
        t_event            got;
        t_event            exp_ev;
        int                n;
        logic [1:0]        final_pos;
        logic [2:0]        changed;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [7:0]        b;

        if (!i_rst_n) begin
            wheel_mode = 1'b0;
            hdr_byte   = '0;
            x_raw      = '0;
            y_raw      = '0;
            byte_pos   = '0;
            cursor_x   = '0;
            cursor_y   = '0;
            prev_btn   = '0;
            pending_events.delete();
        end else begin
            if (i_cfg_we) begin
                wheel_mode = i_cfg_wdata;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                b = s_axis_tdata;
                final_pos = wheel_mode ? 2'd3 : 2'd2;
                // drop a would-be header without the sync bit
                if (!(byte_pos == 2'd0 && !b[SYNC_BIT])) begin
                    case (byte_pos)
                        2'd0: hdr_byte = b;
                        2'd1: x_raw = b;
                        2'd2: y_raw = b;
                        default: ;
                    endcase
                    if (byte_pos < final_pos) begin
                        byte_pos = byte_pos + 2'd1;
                    end else begin
                        dx = clamp_delta(x_raw, hdr_byte[X_OVF_BIT]);
                        dy = clamp_delta(y_raw, hdr_byte[Y_OVF_BIT]);
                        changed = hdr_byte[2:0] ^ prev_btn;
                        cursor_x = cursor_x + {{24{dx[7]}}, dx};
                        cursor_y = cursor_y - {{24{dy[7]}}, dy};
                        n = 0;
                        evs[0] = '0;
                        evs[0].kind    = EV_MOVE;
                        evs[0].dx      = dx;
                        evs[0].dy      = dy;
                        evs[0].buttons = hdr_byte[2:0];
                        evs[0].pos_x   = cursor_x;
                        evs[0].pos_y   = cursor_y;
                        n = 1;
                        for (int i = 0; i < NUM_BTN; i++) begin
                            if (changed[i]) begin
                                evs[n] = evs[0];
                                evs[n].kind    = EV_BUTTON;
                                evs[n].dx      = '0;
                                evs[n].dy      = '0;
                                evs[n].index   = 2'(i);
                                evs[n].pressed = hdr_byte[i];
                                n++;
                            end
                        end
                        prev_btn = hdr_byte[2:0];
                        // a late byte in 3-byte mode only closes the packet
                        if (wheel_mode && byte_pos == 2'd3 && b != 8'd0) begin
                            evs[n] = evs[0];
                            evs[n].kind  = EV_WHEEL;
                            evs[n].dx    = '0;
                            evs[n].dy    = '0;
                            evs[n].wheel = signed'(b);
                            n++;
                        end
                        evs[n-1].last = 1'b1;
                        for (int i = 0; i < n; i++) begin
                            pending_events.push_back(evs[i]);
                        end
                        byte_pos = 2'd0;
                    end
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.kind    = t_event_kind'(m_axis_tuser);
                got.dx      = m_axis_tdata[7:0];
                got.dy      = m_axis_tdata[15:8];
                got.buttons = m_axis_tdata[18:16];
                got.index   = m_axis_tdata[20:19];
                got.pressed = m_axis_tdata[21];
                got.wheel   = m_axis_tdata[29:22];
                got.pos_x   = m_axis_tdata[61:30];
                got.pos_y   = m_axis_tdata[93:62];
                got.last    = m_axis_tlast;
                if (pending_events.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: event with nothing pending: kind %0d dx %0d dy %0d",
                                 $realtime, got.kind, got.dx, got.dy);
                    end
                    mismatch_count++;
                end else begin
                    exp_ev = pending_events.pop_front();
                    if (got.kind !== exp_ev.kind || got.dx !== exp_ev.dx
                            || got.dy !== exp_ev.dy || got.buttons !== exp_ev.buttons
                            || got.index !== exp_ev.index || got.pressed !== exp_ev.pressed
                            || got.wheel !== exp_ev.wheel || got.pos_x !== exp_ev.pos_x
                            || got.pos_y !== exp_ev.pos_y || got.last !== exp_ev.last) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: event mismatch (kind dx dy btn idx prs whl x y last)",
                                     $realtime);
                            $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                     exp_ev.kind, exp_ev.dx, exp_ev.dy, exp_ev.buttons,
                                     exp_ev.index, exp_ev.pressed, exp_ev.wheel,
                                     exp_ev.pos_x, exp_ev.pos_y, exp_ev.last);
                            $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                                     got.kind, got.dx, got.dy, got.buttons,
                                     got.index, got.pressed, got.wheel,
                                     got.pos_x, got.pos_y, got.last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= pending_events.size();
        o_fails   <= mismatch_count;
    end

endmodule

[tb/testbench.sv]
// Top of the PS/2 mouse packet decoder testbench: clock, reset, byte stimulus,
// receiver back-pressure and the verdict. Depends on ps2_event_checker and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
    import ps2md_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          events_pending;
    int          fail_count;

    logic        mode_now;      // wheel mode as last written
    logic [1:0]  pkt_pos;       // where the next byte lands in the packet
    int          fed;           // bytes that the decoder actually uses
    int          burst_left;
    logic        hold_req;
    logic        hold_done;

    ps2_mouse_packet_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ps2_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_pending     (events_pending),
        .o_fails       (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ps2_mouse_packet_decoder verification failed");
        $finish;
    end

    // Receiver: stall on a changing pattern, plus one long hold-off on request.
    initial begin : receiver
        int style;
        int span;
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_req && !hold_done) begin
                    m_axis_tready = 1'b0;
                    repeat (80) @(negedge i_clk);
                    hold_done = 1'b1;
                end
                case (style)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = 1'($urandom_range(0, 1));
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Offer one byte in bursts with random gaps; return at the accepting edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // track packet position: unsynced headers are dropped
        if (!(pkt_pos == 2'd0 && !b[SYNC_BIT])) begin
            fed++;
            if (pkt_pos >= (mode_now ? 2'd3 : 2'd2)) begin
                pkt_pos = 2'd0;
            end else begin
                pkt_pos = pkt_pos + 2'd1;
            end
        end
    endtask

    // Stop offering, then wait until every predicted event has left the block.
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (events_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic wheel);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = wheel;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        mode_now    = wheel;
    endtask

    initial begin : stimulus
        logic [7:0] b;
        int         phase_end;
        int         pick;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        hold_req      = 1'b0;
        mode_now      = 1'b0;
        pkt_pos       = 2'd0;
        fed           = 0;
        burst_left    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // headers without the sync bit
        send_byte(8'h00);
        send_byte(8'hF7);
        // full-scale deltas, no buttons
        send_byte(8'h08); send_byte(8'h7F); send_byte(8'h80);
        // all three buttons go down
        send_byte(8'h0F); send_byte(8'h01); send_byte(8'hFF);
        // both overflow bits: zero X delta goes negative, buttons released
        send_byte(8'hC8); send_byte(8'h00); send_byte(8'h05);
        // X overflow on a negative delta
        send_byte(8'h4A); send_byte(8'h90); send_byte(8'h00);

        write_mode(1'b1);
        send_byte(8'h0D); send_byte(8'h10); send_byte(8'hF0); send_byte(8'h7F);
        // zero wheel byte gives no wheel event
        send_byte(8'h08); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        // leave wheel mode with three bytes stored; the next byte closes the packet
        send_byte(8'h09); send_byte(8'h05); send_byte(8'h06);
        write_mode(1'b0);
        send_byte(8'h55);

        fed = 0;
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase == 3 ? 1'($urandom_range(0, 1)) : ((phase % 2) == 0));
            phase_end = fed + 24;
            while (fed < phase_end) begin
                if (phase == 2 && fed == phase_end - 18) begin
                    hold_req = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pkt_pos == 2'd0) begin
                    if (pick == 0) begin
                        b = 8'($urandom) & 8'hF7;
                    end else if (pick == 1) begin
                        b = 8'($urandom);
                    end else begin
                        b = 8'($urandom) | 8'h08;
                    end
                end else if (pick < 2) begin
                    case ($urandom_range(0, 4))
                        0:       b = 8'h00;
                        1:       b = 8'h01;
                        2:       b = 8'h7F;
                        3:       b = 8'h80;
                        default: b = 8'hFF;
                    endcase
                end else if (pkt_pos == 2'd3 && pick < 4) begin
                    b = 8'h00;
                end else begin
                    b = 8'($urandom);
                end
                send_byte(b);
            end
        end
        // close any partial packet so nothing is left half-assembled
        while (pkt_pos != 2'd0) send_byte(8'($urandom));

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && events_pending == 0) begin
            $display("ps2_mouse_packet_decoder verification clean");
        end else begin
            $display("ps2_mouse_packet_decoder verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ps2md_pkg.sv
rtl/ps2md_emit.sv
rtl/ps2_mouse_packet_decoder.sv
tb/ps2_event_checker.sv
tb/testbench.sv
